// ----- design/ggpc_pkg.sv -----
`timescale 1ns / 1ps

package ggpc_pkg;

   // defaults for the top-level parameters
   localparam int FRAC_BITS_DEF     = 12;
   localparam int CORDIC_STAGES_DEF = 16;

   // CORDIC internals: guard bits on the error vector, Q2.30 angles
   localparam int GUARD    = 8;
   localparam int ANG_BITS = 30;

   // field widths
   localparam int POS_W   = 18;
   localparam int HD_W    = 15;
   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 17;
   localparam int FWD_W   = 17;
   localparam int TURN_W  = 16;

   // datapath widths
   localparam int XY_W   = 30;  // error vector with guard bits and CORDIC growth
   localparam int Z_W    = 34;  // accumulated angle, Q2.30 plus headroom
   localparam int INV_W  = 30;
   localparam int DIST_W = 21;

   // stream and register port widths
   localparam int REQ_W  = 56;
   localparam int RSP_W  = 40;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic signed [Z_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
   localparam logic [INV_W-1:0]      INV_GAIN_Q30 = 30'd652032874;

   typedef enum logic [1:0] {
      REG_GOAL_X      = 2'd0,
      REG_GOAL_Y      = 2'd1,
      REG_GAIN        = 2'd2,
      REG_SPEED_LIMIT = 2'd3
   } ggpc_reg_type;

   // payload handed from cell to cell
   typedef struct packed {
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
      logic [Z_W-1:0]  z;
      logic [HD_W-1:0] hd;
   } ggpc_vec_type;

   // atan(2^-i) in Q2.30; beyond the table the angle is 2^-i itself
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      logic signed [Z_W-1:0] one;
      logic signed [Z_W-1:0] res;
      one = 1;
      case (idx)
         0: res = 34'sd843314857;
         1: res = 34'sd497837829;
         2: res = 34'sd263043837;
         3: res = 34'sd133525159;
         4: res = 34'sd67021687;
         5: res = 34'sd33543516;
         6: res = 34'sd16775851;
         7: res = 34'sd8388437;
         8: res = 34'sd4194283;
         9: res = 34'sd2097149;
         default: res = one <<< (ANG_BITS - idx);
      endcase
      return res;
   endfunction

endpackage

// ----- design/go_to_goal_p_controller_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  pose: pos_x, pos_y, heading
// rsp       out        rsp_tvalid/rsp_tready  command: forward_speed, turn_rate
// csr       in/out     psel/penable/pready    goal_x, goal_y, gain, speed_limit
//
// Throughput is one transaction per cycle while rsp_tready is high; the stages are the
// error/fold cell, one cell per CORDIC micro-rotation and the four post stages.
// Reset is synchronous: all valid flags drop and the registers take their defaults.
// Every stage holds its item only while the one downstream is full and stalled,
// so bubbles close up and req_tready stays high until the whole chain is full.

module go_to_goal_p_controller_top #(
   parameter int FRAC_BITS     = ggpc_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = ggpc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // pose transaction
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ggpc_pkg::REQ_W-1:0]  req_tdata,   // pos_x[17:0], pos_y[35:18], heading[50:36]
   // command transaction
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ggpc_pkg::RSP_W-1:0]  rsp_tdata,   // forward_speed[16:0], turn_rate[32:17]
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ggpc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ggpc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ggpc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import ggpc_pkg::*;

   localparam int DEPTH  = CORDIC_STAGES + 5;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int THR_ANG = ((1 << (FRAC_BITS + 1)) + 5) / 10;
   localparam logic signed [TURN_W:0] THR_ANG_V = (TURN_W+1)'(THR_ANG);

   // ---------------- registers ----------------
   logic [POS_W-1:0]   goal_x_ff, goal_x_in;
   logic [POS_W-1:0]   goal_y_ff, goal_y_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [LIMIT_W-1:0] speed_limit_ff, speed_limit_in;
   logic               csr_wr;
   ggpc_reg_type       csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = ggpc_reg_type'(csr_paddr[3:2]);

   always_comb begin
      goal_x_in      = goal_x_ff;
      goal_y_in      = goal_y_ff;
      gain_in        = gain_ff;
      speed_limit_in = speed_limit_ff;
      if (csr_wr) begin
         case (csr_sel)
            REG_GOAL_X:      goal_x_in      = csr_pwdata[POS_W-1:0];
            REG_GOAL_Y:      goal_y_in      = csr_pwdata[POS_W-1:0];
            REG_GAIN:        gain_in        = csr_pwdata[GAIN_W-1:0];
            REG_SPEED_LIMIT: speed_limit_in = csr_pwdata[LIMIT_W-1:0];
            default:         goal_x_in      = goal_x_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_GOAL_X:      csr_prdata = CSR_DW'(goal_x_ff);
         REG_GOAL_Y:      csr_prdata = CSR_DW'(goal_y_ff);
         REG_GAIN:        csr_prdata = CSR_DW'(gain_ff);
         REG_SPEED_LIMIT: csr_prdata = CSR_DW'(speed_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff      <= POS_W'(12288);   // 3.0
         goal_y_ff      <= POS_W'(8192);    // 2.0
         gain_ff        <= GAIN_W'(4096);   // 1.0
         speed_limit_ff <= LIMIT_W'(12288); // 3.0
      end else begin
         goal_x_ff      <= goal_x_in;
         goal_y_ff      <= goal_y_in;
         gain_ff        <= gain_in;
         speed_limit_ff <= speed_limit_in;
      end
   end

   // ---------------- cell chain ----------------
   // index 0 is the fold cell output, index k the output of micro-rotation k-1
   logic         vld [0:CORDIC_STAGES];
   logic         rdy [0:CORDIC_STAGES];
   ggpc_vec_type dat [0:CORDIC_STAGES];

   ggpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pos_x     (req_tdata[17:0]),
      .pos_y     (req_tdata[35:18]),
      .heading   (req_tdata[50:36]),
      .goal_x    (goal_x_ff),
      .goal_y    (goal_y_ff),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .out_data  (dat[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      ggpc_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_data   (dat[g]),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_data  (dat[g+1])
      );
   end

   logic [FWD_W-1:0]  rsp_fwd;
   logic [TURN_W-1:0] rsp_turn;

   ggpc_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (vld[CORDIC_STAGES]),
      .in_ready      (rdy[CORDIC_STAGES]),
      .in_data       (dat[CORDIC_STAGES]),
      .gain          (gain_ff),
      .speed_limit   (speed_limit_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .forward_speed (rsp_fwd),
      .turn_rate     (rsp_turn)
   );

   assign rsp_tdata = {(RSP_W - FWD_W - TURN_W)'(0), rsp_turn, rsp_fwd};

   // ---------------- checks ----------------
   // items in flight: accepted poses not yet delivered as commands
   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // turning in place and driving straight never mix
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_fwd == '0) || (rsp_turn == '0))
      else $error("forward speed and turn rate both nonzero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (FWD_W'(rsp_fwd) <= speed_limit_ff))
      else $error("forward speed above limit");

   // a nonzero turn only comes out past the angle dead band
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_turn != '0)) |->
         ((TURN_W+1)'($signed(rsp_turn)) > THR_ANG_V) ||
         ((TURN_W+1)'($signed(rsp_turn)) < -THR_ANG_V))
      else $error("turn rate inside dead band");

   assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(DEPTH))
      else $error("more transactions in flight than pipeline stages");

   assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == '0) |-> !rsp_tvalid)
      else $error("command without a pending pose");

endmodule

// ----- design/ggpc_front.sv -----
`timescale 1ns / 1ps

module ggpc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [ggpc_pkg::POS_W-1:0] pos_x,
   input  logic [ggpc_pkg::POS_W-1:0] pos_y,
   input  logic [ggpc_pkg::HD_W-1:0]  heading,
   input  logic [ggpc_pkg::POS_W-1:0] goal_x,
   input  logic [ggpc_pkg::POS_W-1:0] goal_y,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ggpc_pkg::ggpc_vec_type    out_data
);
   import ggpc_pkg::*;

   logic                   vld_ff, vld_in;
   ggpc_vec_type           data_ff, data_in;
   logic signed [POS_W:0]  ex, ey;
   logic signed [XY_W-1:0] x0, y0;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   always_comb begin
      ex = (POS_W+1)'($signed(goal_x)) - (POS_W+1)'($signed(pos_x));
      ey = (POS_W+1)'($signed(goal_y)) - (POS_W+1)'($signed(pos_y));
      x0 = XY_W'(ex) <<< GUARD;
      y0 = XY_W'(ey) <<< GUARD;
      data_in.hd = heading;
      // fold the left half plane onto the right one
      if (x0 < 0) begin
         if (y0 >= 0) begin
            data_in.x = y0;
            data_in.y = -x0;
            data_in.z = HALF_PI_Q30;
         end else begin
            data_in.x = -y0;
            data_in.y = x0;
            data_in.z = -HALF_PI_Q30;
         end
      end else begin
         data_in.x = x0;
         data_in.y = y0;
         data_in.z = '0;
      end
      vld_in = in_ready ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- design/ggpc_cell.sv -----
`timescale 1ns / 1ps

module ggpc_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ggpc_pkg::ggpc_vec_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ggpc_pkg::ggpc_vec_type out_data
);
   import ggpc_pkg::*;

   localparam logic signed [Z_W-1:0] ANG = atan_entry(STAGE);

   logic                   vld_ff, vld_in;
   ggpc_vec_type           data_ff, data_in;
   logic signed [XY_W-1:0] xv, yv, xs, ys;
   logic signed [Z_W-1:0]  zv;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   // one micro-rotation toward the x axis
   always_comb begin
      xv = $signed(in_data.x);
      yv = $signed(in_data.y);
      zv = $signed(in_data.z);
      xs = xv >>> STAGE;
      ys = yv >>> STAGE;
      data_in.hd = in_data.hd;
      if (yv > 0) begin
         data_in.x = xv + ys;
         data_in.y = yv - xs;
         data_in.z = zv + ANG;
      end else begin
         data_in.x = xv - ys;
         data_in.y = yv + xs;
         data_in.z = zv - ANG;
      end
      vld_in = in_ready ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- design/ggpc_post.sv -----
`timescale 1ns / 1ps

module ggpc_post #(
   parameter int FRAC_BITS = ggpc_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ggpc_pkg::ggpc_vec_type      in_data,
   input  logic [ggpc_pkg::GAIN_W-1:0]  gain,
   input  logic [ggpc_pkg::LIMIT_W-1:0] speed_limit,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ggpc_pkg::FWD_W-1:0]   forward_speed,
   output logic [ggpc_pkg::TURN_W-1:0]  turn_rate
);
   import ggpc_pkg::*;

   localparam int PROD_W  = XY_W - 1 + INV_W;
   localparam int GPROD_W = GAIN_W + DIST_W;
   localparam int ERR_W   = Z_W + 1;
   localparam int ZSH     = ANG_BITS - FRAC_BITS;
   localparam int DSH     = ANG_BITS + GUARD;
   localparam int THR_DIST = ((1 << FRAC_BITS) + 5) / 10;
   localparam int THR_ANG  = ((1 << (FRAC_BITS + 1)) + 5) / 10;
   localparam logic [DIST_W-1:0]       THR_DIST_V = DIST_W'(THR_DIST);
   localparam logic signed [ERR_W-1:0] THR_ANG_V  = ERR_W'(THR_ANG);
   localparam logic signed [ERR_W-1:0] TURN_MAX   = ERR_W'((1 << (TURN_W - 1)) - 1);
   localparam logic signed [ERR_W-1:0] TURN_MIN   = -ERR_W'(1 << (TURN_W - 1));
   localparam logic [PROD_W-1:0]       DIST_HALF  = PROD_W'(1) << (DSH - 1);
   localparam logic signed [Z_W-1:0]   BEAR_HALF  = Z_W'(1) <<< (ZSH - 1);

   // stage valids and loads
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ld1, ld2, ld3, ld4;

   // stage 1: magnitude scaling product, rounded bearing
   logic [XY_W-2:0]        xc;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [Z_W-1:0]  bsum, bear_ff, bear_in;
   logic [HD_W-1:0]        hd1_ff;
   // stage 2: distance and heading error
   logic [PROD_W-1:0]      dsum;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   // stage 3: decision and speed product
   logic                   far, steep;
   logic                   drive_ff, drive_in;
   logic [TURN_W-1:0]      turn3_ff, turn3_in;
   logic [GPROD_W-1:0]     gprod_ff, gprod_in;
   // stage 4: output register
   logic [GPROD_W-1:0]     fwd_full;
   logic [FWD_W-1:0]       fwd_ff, fwd_in;
   logic [TURN_W-1:0]      turn_ff;

   assign ld4      = !v4_ff || out_ready;
   assign ld3      = !v3_ff || ld4;
   assign ld2      = !v2_ff || ld3;
   assign ld1      = !v1_ff || ld2;
   assign in_ready = ld1;

   assign out_valid     = v4_ff;
   assign forward_speed = fwd_ff;
   assign turn_rate     = turn_ff;

   always_comb begin
      xc      = in_data.x[XY_W-1] ? '0 : in_data.x[XY_W-2:0];
      prod_in = PROD_W'(xc) * PROD_W'(INV_GAIN_Q30);
      bsum    = $signed(in_data.z) + BEAR_HALF;
      bear_in = bsum >>> ZSH;
   end

   always_comb begin
      dsum    = prod_ff + DIST_HALF;
      dist_in = DIST_W'(dsum >> DSH);
      err_in  = ERR_W'(bear_ff) - ERR_W'($signed(hd1_ff));
   end

   always_comb begin
      far      = dist_ff > THR_DIST_V;
      steep    = (err_ff > THR_ANG_V) || (err_ff < -THR_ANG_V);
      drive_in = far && !steep;
      gprod_in = GPROD_W'(gain) * GPROD_W'(dist_ff);
      if (!(far && steep)) begin
         turn3_in = '0;
      end else if (err_ff > TURN_MAX) begin
         turn3_in = TURN_MAX[TURN_W-1:0];
      end else if (err_ff < TURN_MIN) begin
         turn3_in = TURN_MIN[TURN_W-1:0];
      end else begin
         turn3_in = err_ff[TURN_W-1:0];
      end
   end

   always_comb begin
      fwd_full = gprod_ff >> FRAC_BITS;
      if (!drive_ff) begin
         fwd_in = '0;
      end else if (fwd_full > GPROD_W'(speed_limit)) begin
         fwd_in = speed_limit;
      end else begin
         fwd_in = fwd_full[FWD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= in_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         prod_ff <= prod_in;
         bear_ff <= bear_in;
         hd1_ff  <= in_data.hd;
      end
      if (ld2) begin
         dist_ff <= dist_in;
         err_ff  <= err_in;
      end
      if (ld3) begin
         drive_ff <= drive_in;
         turn3_ff <= turn3_in;
         gprod_ff <= gprod_in;
      end
      if (ld4) begin
         fwd_ff  <= fwd_in;
         turn_ff <= turn3_ff;
      end
   end

endmodule

// ----- tb/sv/tb_go_to_goal_p_controller_top.sv -----
`timescale 1ns / 1ps

module tb_go_to_goal_p_controller_top;
   import ggpc_pkg::*;

   // Checks the go-to-goal steering block end to end. Poses are fed through the
   // req stream and commands collected on the rsp stream. Each accepted pose is
   // run through a local polar/steering calculation against a shadow copy of the
   // registers, and every command transaction is compared with the oldest one
   // still waiting.

   // ---------------------------------------------------------------------
   // constants of the steering law
   // ---------------------------------------------------------------------
   localparam int     FRAC        = FRAC_BITS_DEF;
   localparam int     ROT_STAGES  = CORDIC_STAGES_DEF;
   localparam int     LATENCY     = CORDIC_STAGES_DEF + 5;
   localparam int     PAD_SHIFT   = 8;    // guard bits ahead of the micro-rotations
   localparam int     ANGLE_FRAC  = 30;   // angles kept in Q2.30 inside the rotator
   localparam longint QUARTER_TURN = longint'(1686629713);
   localparam longint CORDIC_INV_K = longint'(652032874);
   localparam longint NEAR_DIST   = ((longint'(1) << FRAC) + 5) / 10;
   localparam longint NEAR_ANGLE  = ((longint'(1) << (FRAC + 1)) + 5) / 10;
   localparam int     HEADING_MAX = 12868;
   localparam int     POS_MAX     = (1 << (POS_W - 1)) - 1;
   localparam int     POS_MIN     = -(1 << (POS_W - 1));
   localparam int     TURN_MAX    = (1 << (TURN_W - 1)) - 1;
   localparam int     TURN_MIN    = -(1 << (TURN_W - 1));
   localparam int     FWD_LSB     = 0;
   localparam int     TURN_LSB    = FWD_W;
   localparam int     HOLD_CYCLES = 300;  // long receiver hold, fills the pipe

   // pose packed in tdata order: pos_x lowest
   typedef struct packed {
      logic signed [HD_W-1:0]  heading;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_x;
   } pose_type;

   typedef struct packed {
      logic signed [TURN_W-1:0] turn_rate;
      logic [FWD_W-1:0]         forward_speed;
   } cmd_type;

   typedef enum {POSE_ANY, POSE_ALIGNED, POSE_NEAR_GOAL, POSE_BORDER} pose_kind_type;

   // ---------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ---------------------------------------------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   wire               req_tready;
   logic [REQ_W-1:0]  req_tdata   = '0;   // pos_x, pos_y, heading (low bits up)
   wire               rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   wire  [RSP_W-1:0]  rsp_tdata;          // forward_speed, turn_rate (low bits up)
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   wire  [CSR_DW-1:0] csr_prdata;
   wire               csr_pready;

   go_to_goal_p_controller_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // shadow registers, reset values of the block
   // ---------------------------------------------------------------------
   logic signed [POS_W-1:0] goal_x_q      = 18'sd12288;
   logic signed [POS_W-1:0] goal_y_q      = 18'sd8192;
   logic [GAIN_W-1:0]       gain_q        = 16'd4096;
   logic [LIMIT_W-1:0]      speed_limit_q = 17'd12288;

   pose_type pose_pending[$];   // poses waiting to be offered
   cmd_type  cmd_expected[$];   // commands owed by the block, oldest first

   int err_count     = 0;
   bit idle_on       = 1'b1;
   int req_gap       = 0;
   int rsp_stall     = 0;
   int hold_left     = 0;
   int hold_requests = 0;
   int holds_served  = 0;

   // ---------------------------------------------------------------------
   // steering prediction
   // ---------------------------------------------------------------------
   function automatic longint rot_angle(input int i);
      case (i)
         0: return longint'(843314857);
         1: return longint'(497837829);
         2: return longint'(263043837);
         3: return longint'(133525159);
         4: return longint'(67021687);
         5: return longint'(33543516);
         6: return longint'(16775851);
         7: return longint'(8388437);
         8: return longint'(4194283);
         9: return longint'(2097149);
         default: return longint'(1) << (ANGLE_FRAC - i);
      endcase
   endfunction

   // distance and bearing from pose to goal, vectoring CORDIC
   function automatic void goal_polar(input pose_type p, output longint goal_range,
                                      output longint bearing);
      longint x, y, z, t, xs, ys;
      x = (longint'(goal_x_q) - longint'($signed(p.pos_x))) * (longint'(1) << PAD_SHIFT);
      y = (longint'(goal_y_q) - longint'($signed(p.pos_y))) * (longint'(1) << PAD_SHIFT);
      z = 0;
      // fold left half plane into the right one
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + rot_angle(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - rot_angle(i);
         end
      end
      if (x < 0) x = 0;
      goal_range = (x * CORDIC_INV_K + (longint'(1) << (ANGLE_FRAC + PAD_SHIFT - 1)))
                   >>> (ANGLE_FRAC + PAD_SHIFT);
      bearing = (z + (longint'(1) << (ANGLE_FRAC - FRAC - 1))) >>> (ANGLE_FRAC - FRAC);
   endfunction

   function automatic cmd_type steer_command(input pose_type p);
      longint goal_range, bearing, herr, speed;
      cmd_type c;
      goal_polar(p, goal_range, bearing);
      herr = bearing - longint'($signed(p.heading));   // not wrapped
      c = '0;
      if (goal_range > NEAR_DIST) begin
         if (herr > NEAR_ANGLE || herr < -NEAR_ANGLE) begin
            // turn in place
            if (herr > TURN_MAX) herr = TURN_MAX;
            if (herr < TURN_MIN) herr = TURN_MIN;
            c.turn_rate = herr[TURN_W-1:0];
         end else begin
            // drive straight, truncated product, capped
            speed = (longint'(gain_q) * goal_range) >>> FRAC;
            if (speed > longint'(speed_limit_q)) speed = longint'(speed_limit_q);
            c.forward_speed = speed[FWD_W-1:0];
         end
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // pose generation
   // ---------------------------------------------------------------------
   function automatic int rand_span(input int lo, input int hi);
      return int'($urandom_range(hi - lo)) + lo;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > POS_MAX) v = POS_MAX;
      if (v < POS_MIN) v = POS_MIN;
      return v[POS_W-1:0];
   endfunction

   function automatic logic signed [HD_W-1:0] clamp_heading(input longint v);
      if (v > HEADING_MAX) v = HEADING_MAX;
      if (v < -HEADING_MAX) v = -HEADING_MAX;
      return v[HD_W-1:0];
   endfunction

   function automatic pose_type pose_at(input longint x, input longint y, input longint h);
      pose_type p;
      p.pos_x   = clamp_pos(x);
      p.pos_y   = clamp_pos(y);
      p.heading = clamp_heading(h);
      return p;
   endfunction

   // point the pose at the goal, off by delta
   function automatic pose_type aim(input pose_type p, input longint delta);
      longint goal_range, bearing;
      goal_polar(p, goal_range, bearing);
      p.heading = clamp_heading(bearing + delta);
      return p;
   endfunction

   function automatic pose_type make_pose(input pose_kind_type kind);
      pose_type p;
      int       scale, mag;
      p.pos_x   = POS_W'($urandom);
      p.pos_y   = POS_W'($urandom);
      p.heading = clamp_heading(rand_span(-HEADING_MAX, HEADING_MAX));
      case (kind)
         POSE_NEAR_GOAL: begin
            p.pos_x = clamp_pos(goal_x_q + rand_span(-700, 700));
            p.pos_y = clamp_pos(goal_y_q + rand_span(-700, 700));
         end
         POSE_ALIGNED: begin
            // spread of distances so both capped and uncapped speeds show up
            scale   = rand_span(4, 18);
            p.pos_x = clamp_pos(goal_x_q + rand_span(-(1 << scale), 1 << scale));
            p.pos_y = clamp_pos(goal_y_q + rand_span(-(1 << scale), 1 << scale));
            p       = aim(p, rand_span(-900, 900));
         end
         POSE_BORDER: begin
            if ($urandom_range(1)) begin
               // distance right around the arrival radius
               mag = rand_span(400, 420) * ($urandom_range(1) ? 1 : -1);
               if ($urandom_range(1)) begin
                  p.pos_x = clamp_pos(goal_x_q + mag);
                  p.pos_y = clamp_pos(goal_y_q + rand_span(-3, 3));
               end else begin
                  p.pos_x = clamp_pos(goal_x_q + rand_span(-3, 3));
                  p.pos_y = clamp_pos(goal_y_q + mag);
               end
               p = aim(p, rand_span(-1000, 1000));
            end else begin
               // heading error right around the turn threshold
               p = aim(p, rand_span(815, 823) * ($urandom_range(1) ? 1 : -1));
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic queue_random_poses(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 35)      pose_pending.push_back(make_pose(POSE_ALIGNED));
         else if (r < 55) pose_pending.push_back(make_pose(POSE_NEAR_GOAL));
         else if (r < 70) pose_pending.push_back(make_pose(POSE_BORDER));
         else             pose_pending.push_back(make_pose(POSE_ANY));
      end
   endtask

   // ---------------------------------------------------------------------
   // register access, setup then access cycle
   // ---------------------------------------------------------------------
   task automatic csr_write(input ggpc_reg_type idx, input logic [CSR_DW-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_GOAL_X:      goal_x_q      = val[POS_W-1:0];
         REG_GOAL_Y:      goal_y_q      = val[POS_W-1:0];
         REG_GAIN:        gain_q        = val[GAIN_W-1:0];
         REG_SPEED_LIMIT: speed_limit_q = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy,
                               input logic [GAIN_W-1:0] g, input logic [LIMIT_W-1:0] lim);
      csr_write(REG_GOAL_X, CSR_DW'(gx));
      csr_write(REG_GOAL_Y, CSR_DW'(gy));
      csr_write(REG_GAIN, CSR_DW'(g));
      csr_write(REG_SPEED_LIMIT, CSR_DW'(lim));
   endtask

   // block is idle once every pose went in and every command came out
   task automatic wait_drained();
      while (pose_pending.size() != 0 || cmd_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // pose driver: holds an offer until it is taken, random gaps in between
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : offer_poses
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            cmd_expected.push_back(steer_command(pose_pending.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pose_pending.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_W'(pose_pending[0]);
               if (idle_on && $urandom_range(9) == 0) req_gap = $urandom_range(15, 1);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // command monitor: compares each transaction, drives backpressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : accept_commands
      cmd_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_expected.size() == 0) begin
               $error("unexpected command transaction: forward_speed %0d turn_rate %0d",
                      rsp_tdata[FWD_LSB +: FWD_W], $signed(rsp_tdata[TURN_LSB +: TURN_W]));
               err_count++;
            end else begin
               want = cmd_expected.pop_front();
               if (rsp_tdata[FWD_LSB +: FWD_W] !== want.forward_speed) begin
                  $error("forward_speed mismatch: expected %0d, actual %0d",
                         want.forward_speed, rsp_tdata[FWD_LSB +: FWD_W]);
                  err_count++;
               end
               if (rsp_tdata[TURN_LSB +: TURN_W] !== want.turn_rate) begin
                  $error("turn_rate mismatch: expected %0d, actual %0d",
                         want.turn_rate, $signed(rsp_tdata[TURN_LSB +: TURN_W]));
                  err_count++;
               end
            end
         end
         // a long hold asked by the sequence: the pipe fills, req_tready drops
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(9) == 0) rsp_stall = $urandom_range(15, 1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      pose_type p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: goal (3, 2), gain 1.0, limit 3.0
      idle_on = 1'b1;
      pose_pending.push_back(pose_at(goal_x_q, goal_y_q, 0));             // on the goal
      pose_pending.push_back(pose_at(goal_x_q, goal_y_q, HEADING_MAX));
      pose_pending.push_back(pose_at(POS_MIN, POS_MIN, HEADING_MAX));
      pose_pending.push_back(pose_at(POS_MAX, POS_MAX, -HEADING_MAX));
      pose_pending.push_back(pose_at(POS_MIN, POS_MAX, 0));
      pose_pending.push_back(pose_at(POS_MAX, POS_MIN, 0));
      // goal straight behind on the x axis: fold with zero y, largest turn
      pose_pending.push_back(pose_at(POS_MAX, goal_y_q, -HEADING_MAX));
      pose_pending.push_back(pose_at(POS_MAX, goal_y_q, HEADING_MAX));
      // behind and slightly below: fold the other way
      pose_pending.push_back(pose_at(POS_MAX, goal_y_q + 1, HEADING_MAX));
      pose_pending.push_back(pose_at(POS_MAX, goal_y_q + 1, -HEADING_MAX));
      // arrival radius
      pose_pending.push_back(pose_at(goal_x_q - 409, goal_y_q, 0));
      pose_pending.push_back(pose_at(goal_x_q - 410, goal_y_q, 0));
      pose_pending.push_back(pose_at(goal_x_q - 411, goal_y_q, 0));
      pose_pending.push_back(pose_at(goal_x_q - 4096, goal_y_q, 0));     // speed 1.0
      // turn threshold around an aimed pose
      p = pose_at(0, 0, 0);
      pose_pending.push_back(aim(p, 0));
      pose_pending.push_back(aim(p, 819));
      pose_pending.push_back(aim(p, 820));
      pose_pending.push_back(aim(p, -819));
      pose_pending.push_back(aim(p, -820));
      // far and aimed: speed capped at the limit
      pose_pending.push_back(aim(pose_at(goal_x_q, POS_MIN, 0), 0));
      pose_pending.push_back(aim(pose_at(POS_MIN, goal_y_q, 0), 0));
      queue_random_poses(100);
      wait_drained();

      // goal at origin, largest gain and limit, with a long receiver hold
      apply_config(POS_W'(0), POS_W'(0), {GAIN_W{1'b1}}, {LIMIT_W{1'b1}});
      hold_requests++;
      queue_random_poses(150);
      wait_drained();

      // goal in a corner, no gain, zero limit
      apply_config(POS_W'(POS_MIN), POS_W'(POS_MAX), '0, '0);
      queue_random_poses(150);
      wait_drained();

      // opposite corner, tiny gain and limit
      apply_config(POS_W'(POS_MAX), POS_W'(POS_MIN), GAIN_W'(1), LIMIT_W'(1));
      queue_random_poses(150);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         apply_config(POS_W'($urandom), POS_W'($urandom),
                      GAIN_W'($urandom_range(65535) >> $urandom_range(12)),
                      LIMIT_W'($urandom_range(131071) >> $urandom_range(12)));
         // last phase runs flat out, earlier ones idle at random
         idle_on = (ph != 7) && ($urandom_range(3) != 0);
         if (ph == 4) hold_requests++;
         queue_random_poses(150);
         wait_drained();
      end

      repeat (LATENCY * 2) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- go_to_goal_p_controller_top.f -----
design/ggpc_pkg.sv
design/ggpc_front.sv
design/ggpc_cell.sv
design/ggpc_post.sv
design/go_to_goal_p_controller_top.sv
tb/sv/tb_go_to_goal_p_controller_top.sv
